FILE: design/hta_pkg.sv
`timescale 1ns / 1ps
// Package of the handle table allocator: field widths, operation and status
// codes, configuration register indexes and the table entry type.
// No dependencies.
package hta_pkg;

	localparam int LIMIT_W          = 11;
	localparam int HANDLE_W         = 11;
	localparam int OBJ_W            = 32;
	localparam int RIGHTS_W         = 64;
	localparam int KIND_W           = 4;
	localparam int WORD_W           = 64;
	localparam int POS_W            = 6;
	localparam int CFG_IDX_W        = 1;
	localparam int DEFAULT_CAPACITY = 1024;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
	localparam logic [KIND_W-1:0]  NS_RESET    = 4'd1;

	typedef enum logic [1:0] {
		FN_CREATE    = 2'd0,
		FN_DUPLICATE = 2'd1,
		FN_RESOLVE   = 2'd2,
		FN_CLOSE     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BAD    = 2'd1,
		ST_NOROOM = 2'd2,
		ST_KIND   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY_LIMIT = 1'b0,
		CFG_NAMESPACE_KIND = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [OBJ_W-1:0]    object_id;
		logic [RIGHTS_W-1:0] rights;
		logic [KIND_W-1:0]   kind;
	} entry_t;

	// Verdict of the word scanner on one bitmap word
	typedef struct packed {
		logic             full;
		logic [POS_W-1:0] pos;
		logic             base_ok;
		logic             slot_ok;
	} scan_res_t;

endpackage

FILE: design/hta_scan_unit.sv
`timescale 1ns / 1ps
// Shared word scanner: lowest free bit of one 64-bit bitmap word and the
// limit checks on the word base and on the free slot. Depends on hta_pkg.
module hta_scan_unit
	import hta_pkg::*;
#(
	parameter int CW = 12
) (
	input  logic [WORD_W-1:0]  word,
	input  logic [CW-POS_W-1:0] wnum,
	input  logic [LIMIT_W-1:0] lim,
	output scan_res_t          res
);

	logic [WORD_W-1:0] low_free;
	logic [POS_W-1:0]  pos;
	logic [CW-1:0]     base;
	logic [CW-1:0]     slot;

	// isolate the lowest zero bit as a one-hot word
	assign low_free = ~word & (word + WORD_W'(1));

	always_comb begin
		pos = '0;
		for (int b = 0; b < POS_W; b++) begin
			for (int i = 0; i < WORD_W; i++) begin
				if (((i >> b) & 1) == 1) begin
					pos[b] = pos[b] | low_free[i];
				end
			end
		end
	end

	assign base = {wnum, {POS_W{1'b0}}};
	assign slot = {wnum, pos};

	assign res.full    = &word;
	assign res.pos     = pos;
	assign res.base_ok = base < CW'(lim);
	assign res.slot_ok = slot < CW'(lim);

endmodule

FILE: design/hta_entry_ram.sv
`timescale 1ns / 1ps
// Entry store of the handle table: object id, rights and kind per slot.
// One write port, one registered read port. Depends on hta_pkg.
module hta_entry_ram
	import hta_pkg::*;
#(
	parameter int DEPTH = DEFAULT_CAPACITY,
	parameter int AW    = $clog2(DEFAULT_CAPACITY)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/handle_table_allocator.sv
`timescale 1ns / 1ps
// Handle table allocator: top level with the sequencer, the occupancy bitmap,
// the search hint and the configuration registers. Depends on hta_pkg,
// hta_scan_unit and hta_entry_ram.
//
// Usage:
//   A request (func, handle, object_id, rights, kind) is taken when req_valid
//   is high and req_stall low. The block takes one request at a time and
//   raises req_stall until that request has left for the result register.
//   One result (status, new_handle, found_*) follows each request on
//   res_valid; it holds while res_stall is high, and a new request may be
//   taken meanwhile, but its own result waits in the staging register.
// Steps, from the accepting edge to the edge that loads the result:
//   resolve, close, bad handle at the port: lookup, check, response (a
//   handle that is zero or past the limit goes straight to response).
//   create: fetch, scan, response; duplicate: lookup, check, fetch, scan,
//   response. The scan takes one bitmap word a cycle through the shared word
//   scanner, at most ceil(limit/64) + 1 words; a new request is taken in idle.
// Reset: a clearing pass zeroes the bitmap, one word a cycle, over all
//   ceil(CAPACITY/64) words (16 at the default); no request is taken during
//   it, configuration writes are. Limit resets to 1024, namespace kind to 1.
module handle_table_allocator
	import hta_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [1:0]            func,
	input  logic [HANDLE_W-1:0]   handle,
	input  logic [OBJ_W-1:0]      object_id,
	input  logic [RIGHTS_W-1:0]   rights,
	input  logic [KIND_W-1:0]     kind,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [1:0]            status,
	output logic [HANDLE_W-1:0]   new_handle,
	output logic [OBJ_W-1:0]      found_object,
	output logic [RIGHTS_W-1:0]   found_rights,
	output logic [KIND_W-1:0]     found_kind,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LIMIT_W-1:0]    cfg_data
);

	localparam int WORDS    = (CAPACITY + WORD_W - 1) / WORD_W;
	localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int WN_W     = $clog2(WORDS + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CW       = (IDX_W >= LIMIT_W) ? IDX_W + 1 : LIMIT_W + 1;
	localparam int WC_W     = CW - POS_W;
	localparam int CAP_CLIP = (CAPACITY > 2047) ? 2047 : CAPACITY;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_CHECK,
		S_FETCH,
		S_SCAN,
		S_RESP
	} state_t;

	// control state
	state_t              state_q, nxt_state;
	logic [WN_W-1:0]     clr_q;
	logic [WC_W-1:0]     scan_w_q;
	logic [WC_W-1:0]     ev_w_q;
	logic [LIMIT_W-1:0]  hint_q;
	logic [LIMIT_W-1:0]  cap_q;
	logic [KIND_W-1:0]   ns_q;
	logic                res_valid_q;
	status_t             res_status_q;
	logic [HANDLE_W-1:0] res_nh_q;
	entry_t              res_found_q;

	// request operands and staged result
	func_t               func_q;
	logic [CW-1:0]       idx_q;
	logic [RIGHTS_W-1:0] rights_q;
	logic [KIND_W-1:0]   kind_q;
	entry_t              ent_q;
	status_t             stg_status_q;
	logic [HANDLE_W-1:0] stg_nh_q;
	entry_t              stg_found_q;

	// bitmap memory
	logic [WORD_W-1:0]   bm_mem [WORDS];
	logic [WORD_W-1:0]   bm_rd_q;
	logic                bm_we;
	logic [AW-1:0]       bm_waddr;
	logic [WORD_W-1:0]   bm_wdata;
	logic [AW-1:0]       bm_raddr;

	// entry store
	logic                ent_we;
	entry_t              ent_rd;

	// sequencer decisions
	logic                accept;
	logic                out_free;
	logic [LIMIT_W-1:0]  lim;
	logic [CW-1:0]       lim_cw;
	logic [CW-1:0]       hidx;
	logic [CW-1:0]       slot_cw;
	logic [CW-1:0]       slot1;
	logic                bm_bit;
	logic                fin;
	status_t             fin_status;
	logic [HANDLE_W-1:0] fin_nh;
	entry_t              fin_found;
	logic                go_scan;
	logic                scan_step;
	logic                dup_go;
	logic                hint_we;
	logic [LIMIT_W-1:0]  hint_d;
	scan_res_t           scan_res;

	assign lim      = (cap_q < LIMIT_W'(CAP_CLIP)) ? cap_q : LIMIT_W'(CAP_CLIP);
	assign lim_cw   = CW'(lim);
	assign hidx     = CW'(handle) - CW'(1);
	assign slot_cw  = {ev_w_q, scan_res.pos};
	assign slot1    = slot_cw + CW'(1);
	assign bm_bit   = bm_rd_q[idx_q[POS_W-1:0]];
	assign accept   = req_valid && !req_stall;
	assign out_free = !res_valid_q || !res_stall;

	assign req_stall = (state_q != S_IDLE);

	hta_scan_unit #(
		.CW (CW)
	) u_scan (
		.word (bm_rd_q),
		.wnum (ev_w_q),
		.lim  (lim),
		.res  (scan_res)
	);

	hta_entry_ram #(
		.DEPTH (CAPACITY),
		.AW    (IDX_W)
	) u_entries (
		.clk   (clk),
		.we    (ent_we),
		.waddr (slot_cw[IDX_W-1:0]),
		.wdata (ent_q),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ent_rd)
	);

	// Bitmap: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		bm_rd_q <= bm_mem[bm_raddr];
	end

	// Sequencer: decide the next step, the memory accesses and the result
	always_comb begin
		nxt_state  = state_q;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_nh     = '0;
		fin_found  = '0;
		bm_we      = 1'b0;
		bm_waddr   = ev_w_q[AW-1:0];
		bm_wdata   = '0;
		bm_raddr   = scan_w_q[AW-1:0];
		ent_we     = 1'b0;
		go_scan    = 1'b0;
		scan_step  = 1'b0;
		dup_go     = 1'b0;
		hint_we    = 1'b0;
		hint_d     = hint_q;
		unique case (state_q)
			S_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = clr_q[AW-1:0];
				if (clr_q == WN_W'(WORDS - 1)) begin
					nxt_state = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (func_t'(func) == FN_CREATE) begin
						go_scan   = 1'b1;
						nxt_state = S_FETCH;
					end else if (handle == '0 || hidx >= lim_cw) begin
						fin        = 1'b1;
						fin_status = ST_BAD;
					end else begin
						nxt_state = S_LOOKUP;
					end
				end
			end
			S_LOOKUP: begin
				// fetch the bitmap word and entry of the handle's slot
				bm_raddr  = idx_q[POS_W +: AW];
				nxt_state = S_CHECK;
			end
			S_CHECK: begin
				if (!bm_bit) begin
					fin        = 1'b1;
					fin_status = ST_BAD;
				end else begin
					case (func_q)
						FN_DUPLICATE: begin
							if (ent_rd.kind == ns_q) begin
								fin        = 1'b1;
								fin_status = ST_KIND;
							end else begin
								dup_go    = 1'b1;
								go_scan   = 1'b1;
								nxt_state = S_FETCH;
							end
						end
						FN_RESOLVE: begin
							fin = 1'b1;
							if ((kind_q != '0 && ent_rd.kind != kind_q) ||
							    (ent_rd.rights & rights_q) != rights_q) begin
								fin_status = ST_BAD;
							end else begin
								fin_found = ent_rd;
							end
						end
						FN_CLOSE: begin
							fin      = 1'b1;
							bm_we    = 1'b1;
							bm_waddr = idx_q[POS_W +: AW];
							bm_wdata = bm_rd_q & ~(WORD_W'(1) << idx_q[POS_W-1:0]);
							if (idx_q < CW'(hint_q)) begin
								hint_we = 1'b1;
								hint_d  = idx_q[LIMIT_W-1:0];
							end
						end
						FN_CREATE: begin
							fin        = 1'b1;
							fin_status = ST_BAD;
						end
					endcase
				end
			end
			S_FETCH: begin
				scan_step = 1'b1;
				nxt_state = S_SCAN;
			end
			S_SCAN: begin
				if (!scan_res.base_ok) begin
					fin        = 1'b1;
					fin_status = ST_NOROOM;
				end else if (scan_res.full) begin
					scan_step = 1'b1;
				end else if (!scan_res.slot_ok) begin
					fin        = 1'b1;
					fin_status = ST_NOROOM;
				end else begin
					fin      = 1'b1;
					fin_nh   = slot1[HANDLE_W-1:0];
					bm_we    = 1'b1;
					bm_wdata = bm_rd_q | (WORD_W'(1) << scan_res.pos);
					ent_we   = 1'b1;
					hint_we  = 1'b1;
					hint_d   = slot1[LIMIT_W-1:0];
				end
			end
			S_RESP: begin
				if (out_free) begin
					nxt_state = S_IDLE;
				end
			end
		endcase
		if (fin) begin
			nxt_state = S_RESP;
		end
	end

	// State, counters, hint, configuration and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			scan_w_q     <= '0;
			ev_w_q       <= '0;
			hint_q       <= '0;
			cap_q        <= LIMIT_RESET;
			ns_q         <= NS_RESET;
			res_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_nh_q     <= '0;
			res_found_q  <= '0;
		end else begin
			state_q <= nxt_state;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + WN_W'(1);
			end
			// scan pointer runs one word ahead of the word being judged
			if (go_scan) begin
				scan_w_q <= WC_W'(hint_q[LIMIT_W-1:POS_W]);
			end else if (scan_step) begin
				ev_w_q   <= scan_w_q;
				scan_w_q <= scan_w_q + WC_W'(1);
			end
			if (hint_we) begin
				hint_q <= hint_d;
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CAPACITY_LIMIT: cap_q <= cfg_data;
					CFG_NAMESPACE_KIND: ns_q  <= cfg_data[KIND_W-1:0];
				endcase
			end
			// drop the result once taken; load the staged one when free
			if (state_q == S_RESP && out_free) begin
				res_valid_q  <= 1'b1;
				res_status_q <= stg_status_q;
				res_nh_q     <= stg_nh_q;
				res_found_q  <= stg_found_q;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Request operands, entry payload and staged result
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func_t'(func);
			idx_q    <= hidx;
			rights_q <= rights;
			kind_q   <= kind;
			ent_q    <= '{object_id: object_id, rights: rights, kind: kind};
		end
		if (dup_go) begin
			ent_q <= '{object_id: ent_rd.object_id,
			           rights:    ent_rd.rights & rights_q,
			           kind:      ent_rd.kind};
		end
		if (fin) begin
			stg_status_q <= fin_status;
			stg_nh_q     <= fin_nh;
			stg_found_q  <= fin_found;
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = res_status_q;
	assign new_handle   = res_nh_q;
	assign found_object = res_found_q.object_id;
	assign found_rights = res_found_q.rights;
	assign found_kind   = res_found_q.kind;

	// The hint never points past the largest usable slot count
	a_hint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= LIMIT_W'(CAP_CLIP))
		else $error("search hint beyond capacity");

	// An entry is written only together with its bitmap bit
	a_entry_with_bit: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> (bm_we && state_q == S_SCAN))
		else $error("entry write without bitmap update");

	// A result is raised only out of the response step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_RESP))
		else $error("result raised outside response step");

	// A failed request carries no handle and no found entry
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q != ST_OK) |->
		(res_nh_q == '0 && res_found_q == '0))
		else $error("failed request carries data");

endmodule

FILE: tb/sv/hta_checker.sv
`timescale 1ns / 1ps
// Checker of the handle table allocator: watches the request, result and
// configuration ports, keeps its own copy of the table and compares results.
// Depends on hta_pkg.
module hta_checker
	import hta_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic [1:0]           func,
	input  logic [HANDLE_W-1:0]  handle,
	input  logic [OBJ_W-1:0]     object_id,
	input  logic [RIGHTS_W-1:0]  rights,
	input  logic [KIND_W-1:0]    kind,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  logic [1:0]           status,
	input  logic [HANDLE_W-1:0]  new_handle,
	input  logic [OBJ_W-1:0]     found_object,
	input  logic [RIGHTS_W-1:0]  found_rights,
	input  logic [KIND_W-1:0]    found_kind,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data,
	output int                   mismatch_count,
	output int                   pending_results
);

	localparam int WORDS = (CAPACITY + WORD_W - 1) / WORD_W;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] new_handle;
		logic [OBJ_W-1:0]    object_id;
		logic [RIGHTS_W-1:0] rights;
		logic [KIND_W-1:0]   kind;
	} table_result_t;

	logic [WORD_W-1:0]  occupancy [WORDS];
	entry_t             slot_entry [CAPACITY];
	logic [LIMIT_W-1:0] limit_reg;
	logic [KIND_W-1:0]  ns_kind;
	int unsigned        hint;
	table_result_t      awaited_results [$];
	table_result_t      oldest;
	int                 mismatches;

	function automatic int unsigned usable_slots();
		return (limit_reg < CAPACITY) ? limit_reg : CAPACITY;
	endfunction

	// Slot index behind a handle, or -1 when the handle is not live
	function automatic int find_slot(input logic [HANDLE_W-1:0] h);
		int unsigned idx;
		if (h == '0)
			return -1;
		idx = h;
		idx = idx - 1;
		if (idx >= usable_slots())
			return -1;
		if (!occupancy[idx / WORD_W][idx % WORD_W])
			return -1;
		return idx;
	endfunction

	// First free slot from the word holding the hint; 0 when there is no room
	function automatic logic [HANDLE_W-1:0] claim_slot(input entry_t e);
		int unsigned lim, i, j;
		logic [WORD_W-1:0] w;
		lim = usable_slots();
		i = hint - (hint % WORD_W);
		while (i < lim) begin
			w = occupancy[i / WORD_W];
			if (w != '1) begin
				j = 0;
				while (j < WORD_W && w[j])
					j++;
				i += j;
				if (i >= lim)
					return '0;
				occupancy[i / WORD_W][j] = 1'b1;
				slot_entry[i] = e;
				hint = i + 1;
				return HANDLE_W'(i + 1);
			end
			i += WORD_W;
		end
		return '0;
	endfunction

	task automatic apply_request(input func_t op, input logic [HANDLE_W-1:0] h,
			input logic [OBJ_W-1:0] obj, input logic [RIGHTS_W-1:0] rts,
			input logic [KIND_W-1:0] knd);
		table_result_t r;
		entry_t e;
		int s;
		r = '0;
		case (op)
			FN_CREATE: begin
				e.object_id = obj;
				e.rights = rts;
				e.kind = knd;
				r.new_handle = claim_slot(e);
				if (r.new_handle == '0)
					r.status = ST_NOROOM;
			end
			FN_DUPLICATE: begin
				s = find_slot(h);
				if (s < 0) begin
					r.status = ST_BAD;
				end else if (slot_entry[s].kind == ns_kind) begin
					r.status = ST_KIND;
				end else begin
					e = slot_entry[s];
					e.rights = e.rights & rts;
					r.new_handle = claim_slot(e);
					if (r.new_handle == '0)
						r.status = ST_NOROOM;
				end
			end
			FN_RESOLVE: begin
				s = find_slot(h);
				if (s < 0) begin
					r.status = ST_BAD;
				end else begin
					e = slot_entry[s];
					if ((knd != '0 && e.kind != knd) || (e.rights & rts) != rts) begin
						r.status = ST_BAD;
					end else begin
						r.object_id = e.object_id;
						r.rights = e.rights;
						r.kind = e.kind;
					end
				end
			end
			FN_CLOSE: begin
				s = find_slot(h);
				if (s < 0) begin
					r.status = ST_BAD;
				end else begin
					occupancy[s / WORD_W][s % WORD_W] = 1'b0;
					if (s < hint)
						hint = s;
				end
			end
		endcase
		awaited_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WORDS; w++)
				occupancy[w] = '0;
			limit_reg = LIMIT_RESET;
			ns_kind = NS_RESET;
			hint = 0;
			awaited_results.delete();
			mismatches = 0;
			mismatch_count <= 0;
			pending_results <= 0;
		end else begin
			// results first: a result never belongs to a request taken at the same edge
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result, status %0d new_handle %0d",
							$time, status, new_handle);
				end else begin
					oldest = awaited_results.pop_front();
					if (status !== oldest.status || new_handle !== oldest.new_handle ||
							found_object !== oldest.object_id ||
							found_rights !== oldest.rights || found_kind !== oldest.kind) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: result differs, expected st %0d nh %0d obj %h ",
								"rts %h kind %0d, got st %0d nh %0d obj %h rts %h kind %0d"},
								$time, oldest.status, oldest.new_handle, oldest.object_id,
								oldest.rights, oldest.kind, status, new_handle,
								found_object, found_rights, found_kind);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CAPACITY_LIMIT: limit_reg = cfg_data;
					CFG_NAMESPACE_KIND: ns_kind = cfg_data[KIND_W-1:0];
				endcase
			end
			if (req_valid && !req_stall)
				apply_request(func_t'(func), handle, object_id, rights, kind);
			mismatch_count <= mismatches;
			pending_results <= awaited_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the handle table allocator bench: clock, reset, request and result
// traffic, register writes and the verdict. Depends on hta_pkg, hta_checker
// and handle_table_allocator.
module tb_top;
	import hta_pkg::*;

	localparam int CAPACITY        = DEFAULT_CAPACITY;
	localparam int SETTLE_CYCLES   = 40;   // above the slowest duplicate scan
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASES          = 8;
	localparam int PRESSURE_PHASE  = 5;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [1:0]           func = FN_CREATE;
	logic [HANDLE_W-1:0]  handle = '0;
	logic [OBJ_W-1:0]     object_id = '0;
	logic [RIGHTS_W-1:0]  rights = '0;
	logic [KIND_W-1:0]    kind = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [1:0]           status;
	logic [HANDLE_W-1:0]  new_handle;
	logic [OBJ_W-1:0]     found_object;
	logic [RIGHTS_W-1:0]  found_rights;
	logic [KIND_W-1:0]    found_kind;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY_LIMIT;
	logic [LIMIT_W-1:0]   cfg_data = '0;
	int                   mismatch_count;
	int                   pending_results;

	// traffic shaping, written by the stimulus process only
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	bit hold_off_req = 1'b0;
	int unsigned live_estimate = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	handle_table_allocator #(.CAPACITY(CAPACITY)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.func(func), .handle(handle), .object_id(object_id), .rights(rights), .kind(kind),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .new_handle(new_handle), .found_object(found_object),
		.found_rights(found_rights), .found_kind(found_kind),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	hta_checker #(.CAPACITY(CAPACITY)) table_watch (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.func(func), .handle(handle), .object_id(object_id), .rights(rights), .kind(kind),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .new_handle(new_handle), .found_object(found_object),
		.found_rights(found_rights), .found_kind(found_kind),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .pending_results(pending_results)
	);

	// Mostly back to back, sometimes a few cycles, rarely a long pause
	function automatic int gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_idle();
		return tx_gaps ? gap_len() : 0;
	endfunction

	// Offer one request and hold it until taken. With idle at zero the valid
	// stays high so the next request is offered straight away.
	task automatic issue_request(input func_t op, input logic [HANDLE_W-1:0] h,
			input logic [OBJ_W-1:0] o, input logic [RIGHTS_W-1:0] r,
			input logic [KIND_W-1:0] k, input int idle);
		req_valid <= 1'b1;
		func <= op;
		handle <= h;
		object_id <= o;
		rights <= r;
		kind <= k;
		do
			@(posedge clk);
		while (req_stall);
		if (idle > 0) begin
			req_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
	endtask

	// Directed requests always drop valid afterwards, so a drain may follow any of them
	task automatic directed_op(input func_t op, input logic [HANDLE_W-1:0] h,
			input logic [OBJ_W-1:0] o, input logic [RIGHTS_W-1:0] r,
			input logic [KIND_W-1:0] k);
		issue_request(op, h, o, r, k, 1 + gap_len());
	endtask

	// Register writes drop the enable and wait once more before returning, so the enable never drops and rises in one step
	task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= LIMIT_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every outstanding result, then let the scanner go quiet
	task automatic settle();
		do
			@(posedge clk);
		while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random request. Handles are drawn near the occupied low slots so that
	// most of them hit live entries; a slice of pure noise covers the rest.
	task automatic random_op(input int close_pct, input int unsigned eff, input int idle);
		func_t op;
		logic [HANDLE_W-1:0] h;
		logic [OBJ_W-1:0] o;
		logic [RIGHTS_W-1:0] r;
		logic [KIND_W-1:0] k;
		int unsigned sel, span;
		span = live_estimate + 4;
		if (span > eff)
			span = eff;
		h = HANDLE_W'($urandom_range(1, span));
		o = $urandom;
		r = {$urandom, $urandom};
		k = ($urandom_range(0, 9) == 0) ? KIND_W'($urandom) : KIND_W'($urandom_range(0, 3));
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			op = func_t'($urandom_range(0, 3));
			h = HANDLE_W'($urandom);
		end else if (sel < 36) begin
			op = FN_CREATE;
			if ($urandom_range(0, 3) == 0)
				r = '1;
		end else if (sel < 50) begin
			op = FN_DUPLICATE;
			if ($urandom_range(0, 1) == 0)
				r = '1;
		end else if ($urandom_range(0, 49) < close_pct) begin
			op = FN_CLOSE;
		end else begin
			op = FN_RESOLVE;
			// narrow the required rights so that a fair share of lookups succeed
			case ($urandom_range(0, 6))
				0, 1, 2: r = '0;
				3, 4:    r = 64'd1 << $urandom_range(0, 63);
				5:       r = '1;
				default: ;
			endcase
			if ($urandom_range(0, 1) == 0)
				k = '0;
		end
		case (op)
			FN_CREATE, FN_DUPLICATE: live_estimate++;
			FN_CLOSE: if (live_estimate > 0) live_estimate--;
			default: ;
		endcase
		if (live_estimate > eff)
			live_estimate = eff;
		issue_request(op, h, o, r, k, idle);
	endtask

	// Result side: random stall segments, a free-running mode, and one long
	// hold-off counted here while the sender keeps offering requests.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_done) begin
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!rx_stalls) begin
				res_stall <= 1'b0;
				@(posedge clk);
			end else begin
				res_stall <= ($urandom_range(0, 2) == 0);
				repeat (1 + gap_len()) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int unsigned lim, ns, count, eff;
		int close_pct;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Small table so that it fills within a handful of creates
		write_reg(CFG_CAPACITY_LIMIT, 4);
		write_reg(CFG_NAMESPACE_KIND, 2);
		directed_op(FN_CREATE, 11'd0, 32'hFFFF_FFFF, '1, 4'd2);   // kind equal to namespace, stored as is
		directed_op(FN_CREATE, 11'h7FF, 32'h0, '0, 4'd0);
		directed_op(FN_CREATE, 11'd0, $urandom, {$urandom, $urandom}, 4'd15);
		directed_op(FN_CREATE, 11'd0, 32'h1234_5678, 64'h8000_0000_0000_0001, 4'd5);
		directed_op(FN_CREATE, 11'd0, 32'h1, '1, 4'd3);           // table full
		directed_op(FN_RESOLVE, 11'd0, '0, '0, 4'd0);             // zero handle
		directed_op(FN_RESOLVE, 11'd5, '0, '0, 4'd0);             // past the limit
		directed_op(FN_RESOLVE, 11'd1024, '0, '0, 4'd0);
		directed_op(FN_RESOLVE, 11'd1, '0, '1, 4'd2);
		directed_op(FN_RESOLVE, 11'd1, '0, '0, 4'd3);             // wrong kind
		directed_op(FN_RESOLVE, 11'd2, '0, 64'd1, 4'd0);          // missing rights
		directed_op(FN_DUPLICATE, 11'd1, '0, '1, 4'd0);           // namespace refused
		directed_op(FN_DUPLICATE, 11'd3, '0, '1, 4'd0);           // no room for the copy
		directed_op(FN_CLOSE, 11'd0, '0, '0, 4'd0);
		directed_op(FN_CLOSE, 11'd2, '0, '0, 4'd0);               // lowers the hint
		directed_op(FN_CLOSE, 11'd2, '0, '0, 4'd0);               // slot already free
		directed_op(FN_DUPLICATE, 11'd3, '0, 64'hAAAA_5555_F0F0_0F0F, 4'd0);
		directed_op(FN_RESOLVE, 11'd2, '0, '0, 4'd0);
		directed_op(FN_CLOSE, 11'h7FF, '0, '0, 4'd0);
		settle();

		// Limit of zero: nothing valid, nothing to allocate
		write_reg(CFG_CAPACITY_LIMIT, 0);
		directed_op(FN_CREATE, 11'd0, 32'h5, '1, 4'd1);
		directed_op(FN_RESOLVE, 11'd1, '0, '0, 4'd0);
		settle();

		// Limit above the table size, namespace kind zero
		write_reg(CFG_CAPACITY_LIMIT, 2047);
		write_reg(CFG_NAMESPACE_KIND, 0);
		directed_op(FN_CREATE, 11'd0, $urandom, '1, 4'd0);
		directed_op(FN_DUPLICATE, 11'd5, '0, '1, 4'd0);
		settle();

		// Occupied slot beyond a lowered limit
		write_reg(CFG_CAPACITY_LIMIT, 2);
		directed_op(FN_RESOLVE, 11'd3, '0, '0, 4'd0);
		settle();
		live_estimate = 5;

		// Random phases; the 100 then 40 pair leaves the hint past the limit
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin lim = 64;   ns = 1;  count = 250; tx_gaps = 1; rx_stalls = 1; end
				1: begin lim = 1024; ns = 0;  count = 350; tx_gaps = 1; rx_stalls = 0; end
				2: begin lim = 100;  ns = 15; count = 250; tx_gaps = 0; rx_stalls = 1; end
				3: begin lim = 40;   ns = 15; count = 200; tx_gaps = 1; rx_stalls = 1; end
				4: begin lim = 1;    ns = 3;  count = 100; tx_gaps = 1; rx_stalls = 1; end
				5: begin lim = 7;    ns = 2;  count = 200; tx_gaps = 0; rx_stalls = 1; end
				6: begin lim = 2047; ns = 1;  count = 250; tx_gaps = 0; rx_stalls = 0; end
				default: begin lim = 130; ns = 7; count = 224; tx_gaps = 1; rx_stalls = 1; end
			endcase
			write_reg(CFG_CAPACITY_LIMIT, lim);
			write_reg(CFG_NAMESPACE_KIND, ns);
			eff = (lim < CAPACITY) ? lim : CAPACITY;
			close_pct = $urandom_range(10, 35);
			if (ph == PRESSURE_PHASE)
				hold_off_req = 1'b1;
			for (int n = 0; n < count; n++)
				random_op(close_pct, eff, (n == count - 1) ? 1 + gap_len() : pick_idle());
			settle();
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#15_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
